>>> hdl/lrupr_pkg.sv
package lrupr_pkg;

   localparam int FRAMES_DEF    = 4;
   localparam int PAGE_BITS_DEF = 16;

   localparam int PAGE_FIELD_W = 16;
   localparam int SLOT_FIELD_W = 2;
   localparam int CNT_W        = 32;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_FIELDS_W = 1 + SLOT_FIELD_W + 1 + PAGE_FIELD_W + CNT_W + CNT_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic load;
      logic capture;
      logic commit;
   } lrupr_cmd_type;

endpackage

>>> hdl/lru_page_replacement_top.sv
// Fully associative page frame table with least-recently-used replacement.
// Each page reference on the req channel yields one result on the rsp channel:
// hit or fault, the frame now holding the page, the evicted page if any, and
// saturating fault and reference totals. A reference passes a lookup state,
// for the parallel compare against all frames and the recency stack, and an
// update state for the table, stack and counter write-back. The write-back
// waits while an earlier result is still unaccepted; the next reference is
// taken in the write-back cycle. The result register lets a new reference in
// while a result waits. Frames start empty after reset.
module lru_page_replacement_top
   import lrupr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // page_number[15:0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // page_fault[0], frame_slot[2:1], evicted_valid[3], evicted_page[19:4],
   // fault_total[51:20], reference_total[83:52], zero[87:84]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   lrupr_cmd_type cmd;

   lrupr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lrupr_dp #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

>>> hdl/lrupr_ctrl.sv
module lrupr_ctrl
   import lrupr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output lrupr_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;
   logic       ready;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign ready    = (state_ff == ST_IDLE) || ((state_ff == ST_UPD) && out_free);

   assign req_tready  = ready;
   assign rsp_tvalid  = rsp_valid_ff;
   assign cmd.load    = req_tvalid && ready;
   assign cmd.capture = (state_ff == ST_LOOK);
   assign cmd.commit  = (state_ff == ST_UPD) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_LOOK;
         end
         ST_LOOK: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (out_free) state_in = req_tvalid ? ST_LOOK : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/lrupr_dp.sv
module lrupr_dp
   import lrupr_pkg::*;
#(
   parameter int FRAMES    = FRAMES_DEF,
   parameter int PAGE_BITS = PAGE_BITS_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  lrupr_cmd_type          cmd,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IDX_W  = $clog2(FRAMES);
   localparam int FILL_W = $clog2(FRAMES + 1);

   logic [PAGE_BITS-1:0] page_ff;
   logic [PAGE_BITS-1:0] page_in;
   logic [PAGE_BITS+PAGE_FIELD_W-1:0] page_ext;

   logic [PAGE_BITS-1:0] frame_page_ff [FRAMES];
   logic [FRAMES-1:0]    frame_valid_ff;
   logic [PAGE_BITS-1:0] stack_ff [FRAMES];
   logic [PAGE_BITS-1:0] stack_in [FRAMES];
   logic [FILL_W-1:0]    filled_ff;
   logic [CNT_W-1:0]     fault_cnt_ff;
   logic [CNT_W-1:0]     ref_cnt_ff;
   logic [CNT_W-1:0]     fault_cnt_in;
   logic [CNT_W-1:0]     ref_cnt_in;

   logic             hit_ff;
   logic [IDX_W-1:0] hit_slot_ff;
   logic [IDX_W-1:0] pos_ff;
   logic [IDX_W-1:0] lru_slot_ff;
   logic             hit_in;
   logic [IDX_W-1:0] hit_slot_in;
   logic [IDX_W-1:0] pos_in;
   logic [IDX_W-1:0] lru_slot_in;

   logic                 full;
   logic [IDX_W-1:0]     slot;
   logic [IDX_W-1:0]     promote_pos;
   logic                 evict;
   logic [PAGE_BITS-1:0] ev_page;
   logic [IDX_W+1:0]     slot_ext;
   logic [PAGE_BITS+PAGE_FIELD_W-1:0] ev_ext;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   assign page_ext = {{PAGE_BITS{1'b0}}, req_tdata[PAGE_FIELD_W-1:0]};
   assign page_in  = page_ext[PAGE_BITS-1:0];

   // lookup against the current table
   always_comb begin
      hit_in      = 1'b0;
      hit_slot_in = '0;
      pos_in      = '0;
      lru_slot_in = '0;
      for (int i = FRAMES - 1; i >= 0; i--) begin
         if (frame_valid_ff[i] && (frame_page_ff[i] == page_ff)) begin
            hit_in      = 1'b1;
            hit_slot_in = IDX_W'(i);
         end
         if (frame_valid_ff[i] && (frame_page_ff[i] == stack_ff[0])) begin
            lru_slot_in = IDX_W'(i);
         end
         if ((FILL_W'(i) < filled_ff) && (stack_ff[i] == page_ff)) begin
            pos_in = IDX_W'(i);
         end
      end
   end

   // update of table, stack and counters
   assign full        = (filled_ff == FILL_W'(FRAMES));
   assign evict       = !hit_ff && full;
   assign promote_pos = hit_ff ? pos_ff : '0;

   always_comb begin
      if (hit_ff) slot = hit_slot_ff;
      else if (!full) slot = filled_ff[IDX_W-1:0];
      else slot = lru_slot_ff;
   end

   assign ev_page  = evict ? frame_page_ff[lru_slot_ff] : '0;
   assign ev_ext   = {{PAGE_FIELD_W{1'b0}}, ev_page};
   assign slot_ext = {2'b00, slot};

   always_comb begin
      stack_in = stack_ff;
      if (hit_ff || full) begin
         for (int i = 0; i < FRAMES - 1; i++) begin
            if ((IDX_W'(i) >= promote_pos) && (FILL_W'(i + 1) < filled_ff)) begin
               stack_in[i] = stack_ff[i + 1];
            end
         end
         for (int i = 0; i < FRAMES; i++) begin
            if (FILL_W'(i + 1) == filled_ff) stack_in[i] = page_ff;
         end
      end else begin
         for (int i = 0; i < FRAMES; i++) begin
            if (FILL_W'(i) == filled_ff) stack_in[i] = page_ff;
         end
      end
   end

   assign ref_cnt_in   = (ref_cnt_ff == '1) ? ref_cnt_ff : ref_cnt_ff + 1'b1;
   assign fault_cnt_in = (hit_ff || (fault_cnt_ff == '1)) ? fault_cnt_ff
                                                          : fault_cnt_ff + 1'b1;

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[RSP_FIELDS_W-1:0] = {ref_cnt_in, fault_cnt_in,
                                       ev_ext[PAGE_FIELD_W-1:0], evict,
                                       slot_ext[SLOT_FIELD_W-1:0], !hit_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= '0;
         filled_ff      <= '0;
         fault_cnt_ff   <= '0;
         ref_cnt_ff     <= '0;
      end else if (cmd.commit) begin
         frame_valid_ff[slot] <= 1'b1;
         if (!hit_ff && !full) filled_ff <= filled_ff + 1'b1;
         fault_cnt_ff <= fault_cnt_in;
         ref_cnt_ff   <= ref_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) page_ff <= page_in;
      if (cmd.capture) begin
         hit_ff      <= hit_in;
         hit_slot_ff <= hit_slot_in;
         pos_ff      <= pos_in;
         lru_slot_ff <= lru_slot_in;
      end
      if (cmd.commit) begin
         frame_page_ff[slot] <= page_ff;
         stack_ff            <= stack_in;
         rsp_data_ff         <= rsp_data_in;
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule
